// ===== hw/rtl/trs_affine_matrix_builder_defines.svh =====
// Assertion macros used by the checker file of this block.
// Each macro asserts a property on the rising edge of clk_i, disabled while rst_ni is low.
`ifndef TRS_AFFINE_MATRIX_BUILDER_DEFINES_SVH
`define TRS_AFFINE_MATRIX_BUILDER_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define TAMB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("Port check failed.");

// Consequence must hold in the cycle after the antecedent.
`define TAMB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("Port check failed.");

`endif

// ===== hw/rtl/tamb_pkg.sv =====
`timescale 1ns / 1ps

package tamb_pkg;

  localparam int ANG_W  = 36;
  localparam int AW     = 34;
  localparam int XW     = 33;
  localparam int NUM_W  = 44;
  localparam int DIV_W  = 16;
  localparam int REM_W  = 16;

  localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [XW-1:0]    GAIN_Q30    = 33'sd652032874;
  localparam logic signed [31:0]      ONE_Q16     = 32'sd65536;
  localparam logic [1:0]              LAST_ROW    = 2'd3;

  localparam logic [31:0] ATAN_Q30 [24] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef struct packed {
    logic               kind;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
  } tamb_in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic signed [31:0] col3;
    logic               last_row;
    logic               div_error;
  } tamb_out_t;

  typedef struct packed {
    logic [1:0]       row_index;
    logic             last_row;
    logic             div_error;
    logic             use_div;
    logic [3:0]       neg;
    logic [DIV_W-1:0] div;
    logic [3:0][31:0] fix_col;
  } tamb_row_meta_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/trs_affine_matrix_builder.sv =====
`timescale 1ns / 1ps

// Builds the 4x4 TRS matrix for each request (forward T*Rz*Ry*Rx*S, or the inverse
// S^-1 * R^T * T(-t)) and sends it as four row transfers, row 0 first, one row per cycle while
// out_stall_i is low. A request is taken in any cycle with a free slot in the front pipeline;
// each request holds the last front stage until all four of its rows have gone out through the
// single row-wide result port. The path from input transfer to the first row has CORDIC_STEPS + 8 front
// stages (angle reduction, one CORDIC step per stage, rounding and the matrix products) and
// 46 back stages (row setup, a 44-stage restoring divider that one bit resolves per stage,
// and the output register). Entries are signed Q16.16 and saturate; an inverse request with
// a zero scale returns four all-zero rows with div_error set.
module trs_affine_matrix_builder #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tamb_pkg::tamb_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tamb_pkg::tamb_out_t out_data_o
);
  import tamb_pkg::*;

  localparam int F      = FRAC_BITS;
  localparam int N      = CORDIC_STEPS;
  localparam int CW     = F + 2;
  localparam int RW     = F + 3;
  localparam int FS     = F - 8;
  localparam int KS     = 24 - F;
  localparam int NST    = N + 8;
  localparam int S_FOLD = 2;
  localparam int S_SC   = N + 3;
  localparam int S_M1   = N + 4;
  localparam int S_M2   = N + 5;
  localparam int S_M3   = N + 6;
  localparam int S_M4   = N + 7;
  localparam int RND_C  = 1 << (F - 1);
  localparam int RND_S  = 1 << (29 - F);
  localparam int RND_F  = (FS == 0) ? 0 : (1 << (FS - 1));
  localparam int FPW    = RW + 16;
  localparam int UPW    = RW + 32;
  localparam int USW    = RW + 34;

  typedef logic signed [CW-1:0] cs_t;
  typedef logic signed [RW-1:0] rm_t;

  function automatic cs_t mulr(input cs_t a, input cs_t b);
    logic signed [2*CW-1:0] p;
    p = (2*CW)'(a) * (2*CW)'(b);
    p = p + (2*CW)'(RND_C);
    return CW'(p >>> F);
  endfunction

  // Front pipeline control.
  logic [NST-1:0] fv_q;
  logic [NST:0]   adv;
  logic           en_b;
  logic           emit;
  logic           pop;
  logic [1:0]     ser_row_q;
  logic           out_valid_q;

  assign en_b = !out_valid_q || !out_stall_i;
  assign emit = fv_q[NST-1] && en_b;
  assign pop  = emit && (ser_row_q == LAST_ROW);
  assign adv[NST] = pop;

  for (genvar k = 0; k < NST; k++) begin : g_adv
    assign adv[k] = pop || !(&fv_q[NST-1:k]);
  end

  assign in_stall_o = !adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q      <= '0;
      ser_row_q <= '0;
    end else begin
      if (adv[0]) begin
        fv_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          fv_q[k] <= fv_q[k-1];
        end
      end
      if (emit) begin
        ser_row_q <= ser_row_q + 2'd1;
      end
    end
  end

  // Front pipeline data.
  tamb_in_t                carry_q [NST];
  logic signed [ANG_W-1:0] red_q [3];
  logic signed [ANG_W-1:0] red_d [3];
  logic signed [AW-1:0]    fold_a_d [3];
  logic                    fold_n_d [3];
  logic signed [XW-1:0]    cx_q [N+1][3];
  logic signed [XW-1:0]    cy_q [N+1][3];
  logic signed [AW-1:0]    ca_q [N+1][3];
  logic                    cn_q [N+1][3];
  logic signed [XW-1:0]    cx_d [N][3];
  logic signed [XW-1:0]    cy_d [N][3];
  logic signed [AW-1:0]    ca_d [N][3];
  cs_t                     cos_q [3];
  cs_t                     sin_q [3];
  cs_t                     cos_d [3];
  cs_t                     sin_d [3];
  cs_t czcy_q, czsy_q, szcx_q, szsx_q, szcy_q, szsy_q, czcx_q, czsx_q, cysx_q, cycx_q;
  cs_t sx1_q, cx1_q, sy1_q;
  rm_t                     r_q [3][3];
  rm_t                     r_d [3][3];
  rm_t                     r3_q [3][3];
  logic signed [FPW-1:0]   fp_q [3][3];
  logic signed [FPW-1:0]   fp_d [3][3];
  logic signed [UPW-1:0]   up_q [3][3];
  logic signed [UPW-1:0]   up_d [3][3];
  logic signed [31:0]      fcol_q [3][3];
  logic signed [31:0]      fcol_d [3][3];
  logic signed [NUM_W:0]   num_q [3][4];
  logic signed [NUM_W:0]   num_d [3][4];
  logic [DIV_W-1:0]        ad_q [3];
  logic [DIV_W-1:0]        ad_d [3];
  logic                    sn_q [3];
  logic                    sn_d [3];
  logic                    err_q;
  logic                    err_d;

  always_comb begin
    logic signed [15:0]      ang [3];
    logic signed [ANG_W-1:0] aw;
    ang[0] = carry_q[0].angle_x;
    ang[1] = carry_q[0].angle_y;
    ang[2] = carry_q[0].angle_z;
    for (int l = 0; l < 3; l++) begin
      aw = ANG_W'(ang[l]) <<< 18;
      if (aw > PI_Q30) begin
        red_d[l] = aw - TWO_PI_Q30;
      end else if (aw < -PI_Q30) begin
        red_d[l] = aw + TWO_PI_Q30;
      end else begin
        red_d[l] = aw;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (red_q[l] > HALF_PI_Q30) begin
        fold_a_d[l] = AW'(red_q[l] - PI_Q30);
        fold_n_d[l] = 1'b1;
      end else if (red_q[l] < -HALF_PI_Q30) begin
        fold_a_d[l] = AW'(red_q[l] + PI_Q30);
        fold_n_d[l] = 1'b1;
      end else begin
        fold_a_d[l] = AW'(red_q[l]);
        fold_n_d[l] = 1'b0;
      end
    end
  end

  always_comb begin
    logic signed [AW-1:0] at;
    for (int k = 1; k <= N; k++) begin
      at = AW'({1'b0, ATAN_Q30[k-1]});
      for (int l = 0; l < 3; l++) begin
        if (!ca_q[k-1][l][AW-1]) begin
          cx_d[k-1][l] = cx_q[k-1][l] - (cy_q[k-1][l] >>> (k - 1));
          cy_d[k-1][l] = cy_q[k-1][l] + (cx_q[k-1][l] >>> (k - 1));
          ca_d[k-1][l] = ca_q[k-1][l] - at;
        end else begin
          cx_d[k-1][l] = cx_q[k-1][l] + (cy_q[k-1][l] >>> (k - 1));
          cy_d[k-1][l] = cy_q[k-1][l] - (cx_q[k-1][l] >>> (k - 1));
          ca_d[k-1][l] = ca_q[k-1][l] + at;
        end
      end
    end
  end

  always_comb begin
    logic signed [XW-1:0] xr;
    logic signed [XW-1:0] yr;
    for (int l = 0; l < 3; l++) begin
      xr = cn_q[N][l] ? -cx_q[N][l] : cx_q[N][l];
      yr = cn_q[N][l] ? -cy_q[N][l] : cy_q[N][l];
      cos_d[l] = CW'((xr + XW'(RND_S)) >>> (30 - F));
      sin_d[l] = CW'((yr + XW'(RND_S)) >>> (30 - F));
    end
  end

  always_comb begin
    r_d[0][0] = RW'(czcy_q);
    r_d[0][1] = RW'(mulr(czsy_q, sx1_q)) - RW'(szcx_q);
    r_d[0][2] = RW'(mulr(czsy_q, cx1_q)) + RW'(szsx_q);
    r_d[1][0] = RW'(szcy_q);
    r_d[1][1] = RW'(mulr(szsy_q, sx1_q)) + RW'(czcx_q);
    r_d[1][2] = RW'(mulr(szsy_q, cx1_q)) - RW'(czsx_q);
    r_d[2][0] = -RW'(sy1_q);
    r_d[2][1] = RW'(cysx_q);
    r_d[2][2] = RW'(cycx_q);
  end

  always_comb begin
    logic signed [31:0] tv [3];
    logic signed [15:0] sv [3];
    tv[0] = carry_q[S_M2].trans_x;
    tv[1] = carry_q[S_M2].trans_y;
    tv[2] = carry_q[S_M2].trans_z;
    sv[0] = carry_q[S_M2].scale_x;
    sv[1] = carry_q[S_M2].scale_y;
    sv[2] = carry_q[S_M2].scale_z;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        fp_d[i][j] = FPW'(r_q[i][j]) * FPW'(sv[j]);
        up_d[i][j] = UPW'(r_q[j][i]) * UPW'(tv[j]);
      end
    end
  end

  always_comb begin
    logic signed [15:0]    sv [3];
    logic signed [FPW-1:0] fr;
    logic signed [USW-1:0] us;
    sv[0] = carry_q[S_M3].scale_x;
    sv[1] = carry_q[S_M3].scale_y;
    sv[2] = carry_q[S_M3].scale_z;
    err_d = carry_q[S_M3].kind && ((sv[0] == '0) || (sv[1] == '0) || (sv[2] == '0));
    for (int i = 0; i < 3; i++) begin
      ad_d[i] = sv[i][15] ? DIV_W'(-sv[i]) : DIV_W'(sv[i]);
      sn_d[i] = sv[i][15];
      for (int j = 0; j < 3; j++) begin
        fr = (fp_q[i][j] + FPW'(RND_F)) >>> FS;
        fcol_d[i][j] = sat32(64'(fr));
        num_d[i][j] = (NUM_W+1)'(r3_q[j][i]) <<< KS;
      end
      us = USW'(up_q[i][0]) + USW'(up_q[i][1]) + USW'(up_q[i][2]);
      us = (-us + USW'(RND_C)) >>> F;
      num_d[i][3] = (NUM_W+1)'(us) <<< 8;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      carry_q[0] <= in_data_i;
    end
    for (int k = 1; k < NST; k++) begin
      if (adv[k]) begin
        carry_q[k] <= carry_q[k-1];
      end
    end
    if (adv[1]) begin
      red_q <= red_d;
    end
    if (adv[S_FOLD]) begin
      for (int l = 0; l < 3; l++) begin
        cx_q[0][l] <= GAIN_Q30;
        cy_q[0][l] <= '0;
        ca_q[0][l] <= fold_a_d[l];
        cn_q[0][l] <= fold_n_d[l];
      end
    end
    for (int k = 1; k <= N; k++) begin
      if (adv[S_FOLD+k]) begin
        for (int l = 0; l < 3; l++) begin
          cx_q[k][l] <= cx_d[k-1][l];
          cy_q[k][l] <= cy_d[k-1][l];
          ca_q[k][l] <= ca_d[k-1][l];
          cn_q[k][l] <= cn_q[k-1][l];
        end
      end
    end
    if (adv[S_SC]) begin
      cos_q <= cos_d;
      sin_q <= sin_d;
    end
    if (adv[S_M1]) begin
      czcy_q <= mulr(cos_q[2], cos_q[1]);
      czsy_q <= mulr(cos_q[2], sin_q[1]);
      szcx_q <= mulr(sin_q[2], cos_q[0]);
      szsx_q <= mulr(sin_q[2], sin_q[0]);
      szcy_q <= mulr(sin_q[2], cos_q[1]);
      szsy_q <= mulr(sin_q[2], sin_q[1]);
      czcx_q <= mulr(cos_q[2], cos_q[0]);
      czsx_q <= mulr(cos_q[2], sin_q[0]);
      cysx_q <= mulr(cos_q[1], sin_q[0]);
      cycx_q <= mulr(cos_q[1], cos_q[0]);
      sx1_q  <= sin_q[0];
      cx1_q  <= cos_q[0];
      sy1_q  <= sin_q[1];
    end
    if (adv[S_M2]) begin
      r_q <= r_d;
    end
    if (adv[S_M3]) begin
      fp_q <= fp_d;
      up_q <= up_d;
      r3_q <= r_q;
    end
    if (adv[S_M4]) begin
      fcol_q <= fcol_d;
      num_q  <= num_d;
      ad_q   <= ad_d;
      sn_q   <= sn_d;
      err_q  <= err_d;
    end
  end

  // Row setup: pick the current row of the held matrix and prepare the dividends.
  tamb_row_meta_t   meta_d;
  logic [NUM_W-1:0] dvd_d [4];

  always_comb begin
    logic signed [31:0]     fc [3];
    logic signed [31:0]     tr;
    logic [DIV_W-1:0]       ad;
    logic                   sn;
    logic signed [NUM_W:0]  nm [4];
    logic signed [NUM_W:0]  an;
    logic                   kind;
    kind = carry_q[S_M4].kind;
    unique case (ser_row_q)
      2'd0: begin
        fc = fcol_q[0];
        tr = carry_q[S_M4].trans_x;
        ad = ad_q[0];
        sn = sn_q[0];
        nm = num_q[0];
      end
      2'd1: begin
        fc = fcol_q[1];
        tr = carry_q[S_M4].trans_y;
        ad = ad_q[1];
        sn = sn_q[1];
        nm = num_q[1];
      end
      2'd2: begin
        fc = fcol_q[2];
        tr = carry_q[S_M4].trans_z;
        ad = ad_q[2];
        sn = sn_q[2];
        nm = num_q[2];
      end
      default: begin
        fc = '{default: '0};
        tr = '0;
        ad = '0;
        sn = 1'b0;
        nm = '{default: '0};
      end
    endcase
    meta_d.row_index = ser_row_q;
    meta_d.last_row  = (ser_row_q == LAST_ROW);
    meta_d.div_error = err_q;
    meta_d.use_div   = kind && !err_q && !meta_d.last_row;
    meta_d.div       = ad;
    if (err_q) begin
      meta_d.fix_col = '0;
    end else if (meta_d.last_row) begin
      meta_d.fix_col = {ONE_Q16, 32'd0, 32'd0, 32'd0};
    end else if (!kind) begin
      meta_d.fix_col = {tr, fc[2], fc[1], fc[0]};
    end else begin
      meta_d.fix_col = '0;
    end
    for (int l = 0; l < 4; l++) begin
      an = nm[l][NUM_W] ? -nm[l] : nm[l];
      meta_d.neg[l] = nm[l][NUM_W] ^ sn;
      dvd_d[l] = an[NUM_W-1:0] + NUM_W'(ad >> 1);
    end
  end

  // Back pipeline: restoring division, one quotient bit per stage.
  logic [NUM_W:0]   bv_q;
  tamb_row_meta_t   bm_q [NUM_W+1];
  logic [REM_W-1:0] brem_q [NUM_W+1][4];
  logic [NUM_W-1:0] bdq_q [NUM_W+1][4];
  logic [REM_W-1:0] brem_d [NUM_W][4];
  logic [NUM_W-1:0] bdq_d [NUM_W][4];
  tamb_out_t        out_q;
  tamb_out_t        out_d;

  always_comb begin
    logic [REM_W:0] r2;
    logic [REM_W:0] dv;
    logic           ge;
    for (int s = 1; s <= NUM_W; s++) begin
      dv = {1'b0, bm_q[s-1].div};
      for (int l = 0; l < 4; l++) begin
        r2 = {brem_q[s-1][l], bdq_q[s-1][l][NUM_W-1]};
        ge = (r2 >= dv);
        brem_d[s-1][l] = ge ? REM_W'(r2 - dv) : REM_W'(r2);
        bdq_d[s-1][l]  = {bdq_q[s-1][l][NUM_W-2:0], ge};
      end
    end
  end

  always_comb begin
    logic signed [NUM_W:0] qs;
    logic signed [31:0]    col [4];
    for (int l = 0; l < 4; l++) begin
      qs = {1'b0, bdq_q[NUM_W][l]};
      if (bm_q[NUM_W].neg[l]) begin
        qs = -qs;
      end
      col[l] = bm_q[NUM_W].use_div ? sat32(64'(qs)) : bm_q[NUM_W].fix_col[l];
    end
    out_d.row_index = bm_q[NUM_W].row_index;
    out_d.col0      = col[0];
    out_d.col1      = col[1];
    out_d.col2      = col[2];
    out_d.col3      = col[3];
    out_d.last_row  = bm_q[NUM_W].last_row;
    out_d.div_error = bm_q[NUM_W].div_error;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (en_b) begin
      bv_q        <= {bv_q[NUM_W-1:0], fv_q[NST-1]};
      out_valid_q <= bv_q[NUM_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      bm_q[0] <= meta_d;
      for (int l = 0; l < 4; l++) begin
        brem_q[0][l] <= '0;
        bdq_q[0][l]  <= dvd_d[l];
      end
      for (int s = 1; s <= NUM_W; s++) begin
        bm_q[s]  <= bm_q[s-1];
        brem_q[s] <= brem_d[s-1];
        bdq_q[s]  <= bdq_d[s-1];
      end
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/tamb_port_checker.sv =====
`timescale 1ns / 1ps
`include "trs_affine_matrix_builder_defines.svh"

module tamb_port_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input tamb_pkg::tamb_out_t out_data_o
);
  import tamb_pkg::*;

  `TAMB_ASSERT_SAME(a_last_flag, out_valid_o, out_data_o.last_row == (out_data_o.row_index == LAST_ROW))
  `TAMB_ASSERT_SAME(a_err_zero, out_valid_o && out_data_o.div_error, out_data_o.col0 == '0 && out_data_o.col1 == '0 && out_data_o.col2 == '0 && out_data_o.col3 == '0)
  `TAMB_ASSERT_SAME(a_bottom_row, out_valid_o && out_data_o.last_row && !out_data_o.div_error, out_data_o.col0 == '0 && out_data_o.col1 == '0 && out_data_o.col2 == '0 && out_data_o.col3 == ONE_Q16)
  `TAMB_ASSERT_NEXT(a_row_order, out_valid_o && !out_stall_i && !out_data_o.last_row, !out_valid_o || out_data_o.row_index == 2'($past(out_data_o.row_index) + 2'd1))
  `TAMB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

endmodule

bind trs_affine_matrix_builder tamb_port_checker u_tamb_port_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
